// ===== hdl/palette_nearest_match_crossfade_assert.svh =====
// Assertion macros for the palette crossfade block checker.
`ifndef PALETTE_NEAREST_MATCH_CROSSFADE_ASSERT_SVH
`define PALETTE_NEAREST_MATCH_CROSSFADE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PNMC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PNMC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== hdl/pnmc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the palette crossfade block.
package pnmc_pkg;

    typedef enum logic [1:0] {
        MODE_WRITE_OUT = 2'd0,
        MODE_WRITE_IN  = 2'd1,
        MODE_TICK      = 2'd2,
        MODE_QUERY     = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic        do_hop;
        logic [3:0]  entry_index;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic [3:0]  matched_index;
    } out_item_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    localparam int HOP_W            = 16;
    localparam int WRITABLE_ENTRIES = 16;
    localparam int DIST_W           = 18;
    localparam logic [DIST_W-1:0] DIST_INIT = '1;

    localparam int FRAC_W     = 16;
    localparam int ALPHA_W    = FRAC_W + 1;
    localparam int DIV_CNT_W  = $clog2(FRAC_W);
    localparam int SQ_W       = 2 * FRAC_W;
    localparam int WEIGHT_W   = FRAC_W + 2;
    localparam int CUBE_W     = SQ_W + WEIGHT_W;
    localparam logic [WEIGHT_W-1:0] SMOOTH_THREE = WEIGHT_W'(3 * (1 << FRAC_W));

    typedef struct packed {
        logic              valid;
        rgb_t              from;
        logic [DIST_W-1:0] best_d;
        logic [3:0]        best_j;
        rgb_t              best;
    } match_tok_t;

    typedef struct packed {
        logic       wr_out;
        logic       wr_in;
        logic [3:0] index;
        rgb_t       color;
        logic       hop;
    } cell_ctrl_t;

    typedef enum logic [0:0] {
        S_IDLE,
        S_RUN
    } top_state_t;

    typedef enum logic [2:0] {
        A_IDLE,
        A_DIV,
        A_SQUARE,
        A_CUBE,
        A_DONE
    } alpha_state_t;

    function automatic logic [DIST_W-1:0] sq_dist(input rgb_t p, input rgb_t q);
        logic signed [8:0]  dr;
        logic signed [8:0]  dg;
        logic signed [8:0]  db;
        logic signed [17:0] sr;
        logic signed [17:0] sg;
        logic signed [17:0] sb;
        dr = $signed({1'b0, p.r}) - $signed({1'b0, q.r});
        dg = $signed({1'b0, p.g}) - $signed({1'b0, q.g});
        db = $signed({1'b0, p.b}) - $signed({1'b0, q.b});
        sr = dr * dr;
        sg = dg * dg;
        sb = db * db;
        return DIST_W'($unsigned(sr)) + DIST_W'($unsigned(sg)) + DIST_W'($unsigned(sb));
    endfunction

    function automatic logic [7:0] blend_chan(input logic [7:0] a, input logic [7:0] b,
                                              input logic [ALPHA_W-1:0] alpha);
        logic signed [8:0]  diff;
        logic signed [26:0] prod;
        logic signed [26:0] sum;
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        prod = diff * $signed({1'b0, alpha});
        sum  = $signed({3'b000, a, 16'h0000}) + prod;
        return sum[23:16];
    endfunction

endpackage

// ===== hdl/pnmc_cell.sv =====
// One palette cell: holds an outgoing and an incoming entry and updates the running best match.
module pnmc_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pnmc_pkg::cell_ctrl_t ctrl,
    input  pnmc_pkg::match_tok_t tok_in,
    output pnmc_pkg::match_tok_t tok_out,
    output pnmc_pkg::rgb_t       out_entry
);
    import pnmc_pkg::*;

    localparam logic       WRITABLE = (CELL_INDEX < WRITABLE_ENTRIES);
    localparam logic [3:0] INDEX4   = 4'(CELL_INDEX);

    rgb_t              out_entry_reg;
    rgb_t              in_entry_reg;
    match_tok_t        tok_reg;
    match_tok_t        tok_next;
    logic              hit;
    logic [DIST_W-1:0] sq_d;
    logic              take;

    assign hit = WRITABLE && (ctrl.index == INDEX4);

    always_comb
    begin
        sq_d            = sq_dist(tok_in.from, in_entry_reg);
        take            = sq_d < tok_in.best_d;
        tok_next        = tok_in;
        if (take)
        begin
            tok_next.best_d = sq_d;
            tok_next.best_j = INDEX4;
            tok_next.best   = in_entry_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_entry_reg <= '0;
            in_entry_reg  <= '0;
            tok_reg       <= '0;
        end
        else
        begin
            if (ctrl.hop)
            begin
                out_entry_reg <= in_entry_reg;
            end
            else if (ctrl.wr_out && hit)
            begin
                out_entry_reg <= ctrl.color;
            end
            if (ctrl.wr_in && hit)
            begin
                in_entry_reg <= ctrl.color;
            end
            tok_reg <= tok_next;
        end
    end

    assign tok_out   = tok_reg;
    assign out_entry = out_entry_reg;

endmodule

// ===== hdl/pnmc_alpha.sv =====
// Smoothstep alpha unit: bit-serial frame ratio divide, then two registered multiplies.
module pnmc_alpha (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           launch,
    input  logic [pnmc_pkg::HOP_W-1:0]     frames,
    input  logic [pnmc_pkg::HOP_W-1:0]     hop_len,
    output logic [pnmc_pkg::ALPHA_W-1:0]   alpha,
    output logic                           ready
);
    import pnmc_pkg::*;

    alpha_state_t         state_reg;
    alpha_state_t         state_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [HOP_W-1:0]     rem_reg;
    logic [HOP_W-1:0]     rem_next;
    logic [HOP_W-1:0]     div_reg;
    logic [HOP_W-1:0]     div_next;
    logic [FRAC_W-1:0]    quo_reg;
    logic [FRAC_W-1:0]    quo_next;
    logic [SQ_W-1:0]      sq_reg;
    logic [SQ_W-1:0]      sq_next;
    logic [ALPHA_W-1:0]   alpha_reg;
    logic [ALPHA_W-1:0]   alpha_next;

    logic [HOP_W:0]       shifted;
    logic                 fits;
    logic [WEIGHT_W-1:0]  weight;
    logic [CUBE_W-1:0]    cube;

    always_comb
    begin
        shifted    = {rem_reg, 1'b0};
        fits       = shifted >= {1'b0, div_reg};
        weight     = SMOOTH_THREE - {1'b0, quo_reg, 1'b0};
        cube       = CUBE_W'(sq_reg) * CUBE_W'(weight);
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        quo_next   = quo_reg;
        sq_next    = sq_reg;
        alpha_next = alpha_reg;
        unique case (state_reg) inside
            A_IDLE, A_DONE:
            begin
                if (launch)
                begin
                    rem_next   = frames;
                    div_next   = hop_len;
                    quo_next   = '0;
                    cnt_next   = DIV_CNT_W'(FRAC_W - 1);
                    state_next = A_DIV;
                end
            end
            A_DIV:
            begin
                rem_next = fits ? HOP_W'(shifted - {1'b0, div_reg}) : shifted[HOP_W-1:0];
                quo_next = {quo_reg[FRAC_W-2:0], fits};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = A_SQUARE;
                end
            end
            A_SQUARE:
            begin
                sq_next    = SQ_W'(quo_reg) * SQ_W'(quo_reg);
                state_next = A_CUBE;
            end
            A_CUBE:
            begin
                alpha_next = cube[SQ_W+ALPHA_W-1:SQ_W];
                state_next = A_DONE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            div_reg   <= '0;
            quo_reg   <= '0;
            sq_reg    <= '0;
            alpha_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            div_reg   <= div_next;
            quo_reg   <= quo_next;
            sq_reg    <= sq_next;
            alpha_reg <= alpha_next;
        end
    end

    assign alpha = alpha_reg;
    assign ready = (state_reg == A_DONE);

endmodule

// ===== hdl/palette_nearest_match_crossfade.sv =====
// Top level of the palette crossfade block: item decode, frame counter, cell chain and blend.
//
// Usage:
//   Items enter on start/item and are taken at an edge where start is high and busy is low.
//   Write items (modes 0 and 1) and tick/hop items (mode 2) complete at the accepting edge;
//   busy stays low and no result follows. A query (mode 3) raises busy until its result
//   appears on result, with done high for exactly one cycle; the receiver cannot stall it.
//   The next item can be taken in the done cycle; no new query is taken while one is
//   in flight. Query time is set by the 16-step serial divide plus two multiply stages
//   of the alpha unit, or by the pass of the match transaction down the row of
//   PALETTE_ENTRIES cells, whichever is longer.
//   The hop length register is written on cfg_valid/cfg_data while cfg_ready is high
//   (no query in flight); a write also clears the frame count.
//   Reset clears both palettes to black, the frame count to zero, the hop length to one,
//   and drops any query in flight.
module palette_nearest_match_crossfade #(
    parameter int PALETTE_ENTRIES = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  pnmc_pkg::in_item_t         item,
    output logic                       busy,
    output logic                       done,
    output pnmc_pkg::out_item_t        result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [pnmc_pkg::HOP_W-1:0] cfg_data
);
    import pnmc_pkg::*;

    top_state_t       state_reg;
    top_state_t       state_next;
    logic [HOP_W-1:0] hop_frames_reg;
    logic [HOP_W-1:0] hop_frames_next;
    logic [HOP_W-1:0] frames_reg;
    logic [HOP_W-1:0] frames_next;
    logic             match_done_reg;
    logic             match_done_next;
    match_tok_t       match_reg;
    match_tok_t       match_next;
    out_item_t        result_reg;
    out_item_t        result_next;
    logic             done_reg;
    logic             done_next;

    logic             accept;
    logic             cfg_wr;
    logic             query;
    logic             is_tick;
    logic [HOP_W-1:0] eff_hop;
    logic [HOP_W:0]   tick_count;
    logic             tick_hop;
    rgb_t             from;
    rgb_t             wr_color;
    cell_ctrl_t       ctrl;
    logic [ALPHA_W-1:0] alpha;
    logic             alpha_ready;

    match_tok_t       chain [PALETTE_ENTRIES+1];
    rgb_t             entries [PALETTE_ENTRIES];

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign accept    = start && !busy;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign query     = accept && (item.mode == MODE_QUERY);
    assign is_tick   = accept && (item.mode == MODE_TICK);

    assign eff_hop    = (hop_frames_reg == '0) ? HOP_W'(1) : hop_frames_reg;
    assign tick_count = {1'b0, frames_reg} + 1'b1;
    assign tick_hop   = tick_count >= {1'b0, eff_hop};

    assign wr_color = '{r: item.red_in, g: item.green_in, b: item.blue_in};

    always_comb
    begin
        ctrl.wr_out = accept && (item.mode == MODE_WRITE_OUT);
        ctrl.wr_in  = accept && (item.mode == MODE_WRITE_IN);
        ctrl.index  = item.entry_index;
        ctrl.color  = wr_color;
        ctrl.hop    = is_tick && (item.do_hop || tick_hop);
    end

    always_comb
    begin
        from = '0;
        for (int j = 0; j < PALETTE_ENTRIES; j++)
        begin
            if (j < WRITABLE_ENTRIES && item.entry_index == 4'(j))
            begin
                from = entries[j];
            end
        end
    end

    always_comb
    begin
        chain[0].valid  = query;
        chain[0].from   = from;
        chain[0].best_d = DIST_INIT;
        chain[0].best_j = '0;
        chain[0].best   = '0;
    end

    for (genvar g = 0; g < PALETTE_ENTRIES; g++)
    begin : g_cell
        pnmc_cell #(
            .CELL_INDEX(g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .tok_in   (chain[g]),
            .tok_out  (chain[g+1]),
            .out_entry(entries[g])
        );
    end

    pnmc_alpha u_alpha (
        .clk    (clk),
        .rst_n  (rst_n),
        .launch (query),
        .frames (frames_reg),
        .hop_len(eff_hop),
        .alpha  (alpha),
        .ready  (alpha_ready)
    );

    always_comb
    begin
        hop_frames_next = cfg_wr ? cfg_data : hop_frames_reg;
        if (cfg_wr)
        begin
            frames_next = '0;
        end
        else if (is_tick)
        begin
            frames_next = ctrl.hop ? '0 : tick_count[HOP_W-1:0];
        end
        else
        begin
            frames_next = frames_reg;
        end

        match_next      = match_reg;
        match_done_next = match_done_reg;
        if (query)
        begin
            match_done_next = 1'b0;
        end
        else if (chain[PALETTE_ENTRIES].valid)
        begin
            match_done_next = 1'b1;
            match_next      = chain[PALETTE_ENTRIES];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (query)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (alpha_ready && match_done_reg)
                begin
                    result_next.red_out       = blend_chan(match_reg.from.r, match_reg.best.r, alpha);
                    result_next.green_out     = blend_chan(match_reg.from.g, match_reg.best.g, alpha);
                    result_next.blue_out      = blend_chan(match_reg.from.b, match_reg.best.b, alpha);
                    result_next.matched_index = match_reg.best_j;
                    done_next                 = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            hop_frames_reg <= HOP_W'(1);
            frames_reg     <= '0;
            match_done_reg <= 1'b0;
            match_reg      <= '0;
            result_reg     <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hop_frames_reg <= hop_frames_next;
            frames_reg     <= frames_next;
            match_done_reg <= match_done_next;
            match_reg      <= match_next;
            result_reg     <= result_next;
            done_reg       <= done_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== hdl/pnmc_checker.sv =====
// Port-level checker for the palette crossfade block, with its bind to the top level.
`include "palette_nearest_match_crossfade_assert.svh"

module pnmc_checker #(
    parameter int PALETTE_ENTRIES = 16
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input pnmc_pkg::in_item_t         item,
    input logic                       busy,
    input logic                       done,
    input pnmc_pkg::out_item_t        result,
    input logic                       cfg_valid,
    input logic                       cfg_ready,
    input logic [pnmc_pkg::HOP_W-1:0] cfg_data
);
    import pnmc_pkg::*;

    `PNMC_ASSERT_NEXT(a_done_single, done, !done)
    `PNMC_ASSERT_SAME(a_done_idle, done, !busy)
    `PNMC_ASSERT_NEXT(a_query_holds, start && !busy && item.mode == MODE_QUERY, busy && !done)
    `PNMC_ASSERT_NEXT(a_plain_item, start && !busy && item.mode != MODE_QUERY, !busy && !done)
    `PNMC_ASSERT_SAME(a_index_range, done, (PALETTE_ENTRIES > 16) || (32'(result.matched_index) < PALETTE_ENTRIES))

endmodule

bind palette_nearest_match_crossfade pnmc_checker #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
) u_pnmc_checker (.*);

// ===== bench/tb_palette_nearest_match_crossfade.sv =====
// Self-checking testbench for the palette crossfade block with a built-in palette predictor.
`timescale 1ns / 1ps

module tb_palette_nearest_match_crossfade;
    import pnmc_pkg::*;

    localparam int PAL_N = 16;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    in_item_t item = '0;
    logic busy;
    logic done;
    out_item_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [HOP_W-1:0] cfg_data = '0;

    in_item_t item_backlog[$];
    out_item_t blend_due[$];
    int mismatch_count = 0;
    int gap_left = 0;
    logic idle_on = 1'b0;

    rgb_t out_pal [PAL_N] = '{default: '0};
    rgb_t in_pal [PAL_N] = '{default: '0};
    int unsigned frame_cnt = 0;
    logic [HOP_W-1:0] hop_len = 16'd1;

    int unsigned hop_plan [8] = '{0, 65535, 2, 16, 1, 7, 65535, 40};

    palette_nearest_match_crossfade dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic logic [7:0] mix_channel(input logic [7:0] a, input logic [7:0] b,
                                               input longint unsigned alpha);
        longint unsigned v;
        v = (64'(a) * (64'd65536 - alpha) + 64'(b) * alpha) >> 16;
        return v[7:0];
    endfunction

    task automatic apply_palette_item(input in_item_t it);
        rgb_t c;
        rgb_t src;
        rgb_t dst;
        int unsigned eff_len;
        int dr;
        int dg;
        int db;
        int unsigned sq_d;
        int unsigned best_dist;
        int best_idx;
        longint unsigned t;
        longint unsigned alpha;
        out_item_t res;
        c.r = it.red_in;
        c.g = it.green_in;
        c.b = it.blue_in;
        eff_len = (hop_len == 0) ? 1 : hop_len;
        case (it.mode)
            MODE_WRITE_OUT: out_pal[it.entry_index] = c;
            MODE_WRITE_IN:  in_pal[it.entry_index] = c;
            MODE_TICK:
            begin
                if (!it.do_hop)
                    frame_cnt = frame_cnt + 1;
                if (it.do_hop || frame_cnt >= eff_len)
                begin
                    out_pal = in_pal;
                    frame_cnt = 0;
                end
            end
            MODE_QUERY:
            begin
                src = out_pal[it.entry_index];
                best_idx = 0;
                best_dist = 0;
                for (int j = 0; j < PAL_N; j++)
                begin
                    dr = int'(src.r) - int'(in_pal[j].r);
                    dg = int'(src.g) - int'(in_pal[j].g);
                    db = int'(src.b) - int'(in_pal[j].b);
                    sq_d = dr * dr + dg * dg + db * db;
                    if (j == 0 || sq_d < best_dist)
                    begin
                        best_dist = sq_d;
                        best_idx = j;
                    end
                end
                dst = in_pal[best_idx];
                t = (64'(frame_cnt) << 16) / eff_len;
                if (t > 64'd65536)
                    t = 64'd65536;
                alpha = (t * t * (64'd196608 - 2 * t)) >> 32;
                res.red_out = mix_channel(src.r, dst.r, alpha);
                res.green_out = mix_channel(src.g, dst.g, alpha);
                res.blue_out = mix_channel(src.b, dst.b, alpha);
                res.matched_index = best_idx[3:0];
                blend_due.push_back(res);
            end
        endcase
    endtask

    task automatic flag_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic queue_item(input mode_t m, input logic hop, input int idx,
                              input logic [23:0] colour);
        in_item_t it;
        it.mode = m;
        it.do_hop = hop;
        it.entry_index = idx[3:0];
        {it.red_in, it.green_in, it.blue_in} = colour;
        item_backlog.push_back(it);
    endtask

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'h7f;
            2: return 8'h80;
            3: return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic in_item_t rand_palette_item();
        in_item_t it;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 25)
            it.mode = MODE_WRITE_OUT;
        else if (r < 55)
            it.mode = MODE_WRITE_IN;
        else if (r < 78)
            it.mode = MODE_TICK;
        else
            it.mode = MODE_QUERY;
        it.do_hop = (it.mode == MODE_TICK) ? ($urandom_range(0, 9) == 0) : 1'($urandom);
        it.entry_index = 4'($urandom);
        it.red_in = pick_level();
        it.green_in = pick_level();
        it.blue_in = pick_level();
        return it;
    endfunction

    task automatic wait_idle();
        do @(negedge clk);
        while (item_backlog.size() != 0 || start || blend_due.size() != 0);
        repeat (24) @(negedge clk);
    endtask

    task automatic write_hop_len(input logic [HOP_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk);
        while (!cfg_ready);
        hop_len = v;
        frame_cnt = 0;
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : driver
        logic launch;
        if (!rst_n)
        begin
            start <= 1'b0;
            item <= '0;
            gap_left <= 0;
        end
        else
        begin
            launch = start;
            if (start && !busy)
            begin
                apply_palette_item(item);
                launch = 1'b0;
            end
            if (!launch)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else if (item_backlog.size() != 0)
                begin
                    item <= item_backlog.pop_front();
                    launch = 1'b1;
                    gap_left <= idle_on ? $urandom_range(0, 16) : 0;
                end
            end
            start <= launch;
        end
    end

    always @(negedge clk)
    begin : monitor
        out_item_t want;
        if (rst_n && done === 1'b1)
        begin
            if (blend_due.size() == 0)
                flag_mismatch($sformatf("unexpected transaction %p", result));
            else
            begin
                want = blend_due.pop_front();
                if (result.red_out !== want.red_out)
                    flag_mismatch($sformatf("red_out %0h, want %0h",
                                            result.red_out, want.red_out));
                if (result.green_out !== want.green_out)
                    flag_mismatch($sformatf("green_out %0h, want %0h",
                                            result.green_out, want.green_out));
                if (result.blue_out !== want.blue_out)
                    flag_mismatch($sformatf("blue_out %0h, want %0h",
                                            result.blue_out, want.blue_out));
                if (result.matched_index !== want.matched_index)
                    flag_mismatch($sformatf("matched_index %0d, want %0d",
                                            result.matched_index, want.matched_index));
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_item(MODE_QUERY, 1'b0, 0, 24'h000000);
        queue_item(MODE_WRITE_OUT, 1'b0, 15, 24'hffffff);
        queue_item(MODE_WRITE_IN, 1'b0, 0, 24'h000000);
        queue_item(MODE_WRITE_IN, 1'b0, 15, 24'hffffff);
        queue_item(MODE_WRITE_IN, 1'b0, 7, 24'hffffff);
        queue_item(MODE_QUERY, 1'b0, 15, 24'h000000);
        queue_item(MODE_WRITE_OUT, 1'b1, 0, 24'h807f01);
        queue_item(MODE_QUERY, 1'b1, 0, 24'hffffff);
        queue_item(MODE_TICK, 1'b0, 0, 24'h000000);
        queue_item(MODE_QUERY, 1'b0, 15, 24'h000000);
        wait_idle();

        write_hop_len(16'd4);
        queue_item(MODE_WRITE_IN, 1'b0, 3, 24'h123456);
        queue_item(MODE_WRITE_OUT, 1'b0, 3, 24'haa550f);
        queue_item(MODE_TICK, 1'b0, 9, 24'h000000);
        queue_item(MODE_QUERY, 1'b0, 3, 24'h000000);
        queue_item(MODE_TICK, 1'b0, 0, 24'h000000);
        queue_item(MODE_TICK, 1'b0, 0, 24'h000000);
        queue_item(MODE_QUERY, 1'b0, 3, 24'h000000);
        queue_item(MODE_TICK, 1'b1, 0, 24'h000000);
        queue_item(MODE_QUERY, 1'b0, 3, 24'h000000);
        for (int i = 0; i < 4; i++)
            queue_item(MODE_TICK, 1'b0, 0, 24'h000000);
        queue_item(MODE_QUERY, 1'b0, 7, 24'h000000);
        wait_idle();

        foreach (hop_plan[p])
        begin
            write_hop_len(hop_plan[p][HOP_W-1:0]);
            idle_on = p[0];
            for (int i = 0; i < 170; i++)
                item_backlog.push_back(rand_palette_item());
            wait_idle();
        end

        if (mismatch_count == 0 && blend_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
